// ===== rtl/core/bitset_with_range_any_query_macros.svh =====
// Assertion macros shared by the bit store checker.
`ifndef BITSET_WITH_RANGE_ANY_QUERY_MACROS_SVH
`define BITSET_WITH_RANGE_ANY_QUERY_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define BSRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define BSRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsrq_pkg.sv =====
// Shared widths, defaults and request codes of the bit store.
`timescale 1ns / 1ps
`default_nettype none

package bsrq_pkg;

  localparam int unsigned REQ_W = 2;
  localparam int unsigned POS_W = 17;

  localparam int unsigned NUM_BITS_DEF  = 65536;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ANY   = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/bsrq_ram.sv =====
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bsrq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bitset_with_range_any_query.sv =====
// Bit store with prefix clear, bit get, bit set and an any-bit-in-range query.
`timescale 1ns / 1ps
`default_nettype none

// The bits live in one single-port RAM of ceil(NUM_BITS / WORD_BITS) words,
// and a request with a non-empty range runs as a walk over the words its bit
// range touches, one read (S_RD) and one write-back or test (S_MOD) per word.
// After the transfer in, the states S_DIV and S_FIX locate the first word; a
// range query stops at the first word with a one. Requests whose range is
// empty after clipping to the capacity skip the walk, and those that give a
// result go straight to the response state. A request that gives a result
// takes longer while the previous answer is still stalled at the output.
// After reset the RAM is zeroed one word a cycle, over all NUM_WORDS words,
// with in_stall_o held high. A finished answer waits in an output register,
// so the next request is taken while it is pending.
module bitset_with_range_any_query import bsrq_pkg::*; #(
  parameter int unsigned NUM_BITS  = NUM_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [POS_W-1:0] range_end_i,
  input  logic             bit_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             answer_o
);

  localparam int unsigned NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned OFS_W     = $clog2(WORD_BITS + 1);
  localparam int unsigned BIT_AW    = POS_W + 1;
  localparam int unsigned RECIP_SH  = BIT_AW + 7;
  localparam int unsigned PROD_W    = BIT_AW + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / WORD_BITS);
  localparam logic [BIT_AW-1:0] LIMIT =
    BIT_AW'((NUM_BITS < (2 ** BIT_AW) - 1) ? NUM_BITS : (2 ** BIT_AW) - 1);
  localparam logic [BIT_AW-1:0] WB_A    = BIT_AW'(WORD_BITS);
  localparam logic [OFS_W-1:0]  WB_O    = OFS_W'(WORD_BITS);
  localparam logic [IDX_W-1:0]  LAST_IX = IDX_W'(NUM_WORDS - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  function automatic logic [BIT_AW-1:0] clip_pos(input logic [BIT_AW-1:0] v);
    return (v > LIMIT) ? LIMIT : v;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [IDX_W-1:0]     word_q, word_d;
  logic [IDX_W-1:0]     qe_q, qe_d;
  logic [BIT_AW-1:0]    base_q, base_d;
  logic [BIT_AW-1:0]    start_q, start_d;
  logic [BIT_AW-1:0]    end_q, end_d;
  logic                 wr_q, wr_d;
  logic                 val_q, val_d;
  logic                 hit_q, hit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 answer_q, answer_d;

  logic                 ram_en, ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [BIT_AW-1:0]    pos_x, rend_x, acc_start, acc_end;
  logic                 acc_wr, acc_val;
  logic [PROD_W-1:0]    prod;
  logic [BIT_AW-1:0]    base_est, rem;
  logic [BIT_AW-1:0]    top, hi_abs;
  logic [OFS_W-1:0]     lo, hi;
  logic [WORD_BITS-1:0] mask, ones;
  logic                 last_word, out_free;

  bsrq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign pos_x  = {1'b0, position_i};
  assign rend_x = {1'b0, range_end_i};

  always_comb begin
    acc_start = '0;
    acc_end   = '0;
    acc_wr    = 1'b0;
    acc_val   = 1'b0;
    case (req_type_i)
      REQ_CLEAR: begin
        acc_end = clip_pos(pos_x);
        acc_wr  = 1'b1;
      end
      REQ_GET: begin
        acc_start = clip_pos(pos_x);
        acc_end   = clip_pos(pos_x + BIT_AW'(1));
      end
      REQ_SET: begin
        acc_start = clip_pos(pos_x);
        acc_end   = clip_pos(pos_x + BIT_AW'(1));
        acc_wr    = 1'b1;
        acc_val   = bit_value_i;
      end
      REQ_ANY: begin
        acc_start = clip_pos(pos_x);
        acc_end   = clip_pos(rend_x);
      end
      default: begin
        acc_start = '0;
      end
    endcase
  end

  assign prod     = PROD_W'(start_q) * PROD_W'(RECIP);
  assign base_est = BIT_AW'(BIT_AW'(qe_q) * WB_A);
  assign rem      = start_q - base_est;

  assign ones      = '1;
  assign top       = base_q + WB_A;
  assign hi_abs    = (end_q < top) ? end_q : top;
  assign hi        = OFS_W'(hi_abs - base_q);
  assign lo        = (start_q > base_q) ? OFS_W'(start_q - base_q) : '0;
  assign mask      = (ones << lo) & ((hi == WB_O) ? ones : ~(ones << hi));
  assign last_word = (top >= end_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    qe_d        = qe_q;
    base_d      = base_q;
    start_d     = start_q;
    end_d       = end_q;
    wr_d        = wr_q;
    val_d       = val_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    answer_d    = answer_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = word_q;
    ram_wdata   = val_q ? (ram_rdata | mask) : (ram_rdata & ~mask);

    case (state_q)
      S_INIT: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (word_q == LAST_IX) begin
          word_d  = '0;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          start_d = acc_start;
          end_d   = acc_end;
          wr_d    = acc_wr;
          val_d   = acc_val;
          hit_d   = 1'b0;
          if (acc_start < acc_end) begin
            state_d = S_DIV;
          end else if (!acc_wr) begin
            state_d = S_RESP;
          end
        end
      end
      S_DIV: begin
        qe_d    = IDX_W'(prod >> RECIP_SH);
        state_d = S_FIX;
      end
      S_FIX: begin
        if (rem >= WB_A) begin
          word_d = qe_q + IDX_W'(1);
          base_d = base_est + WB_A;
        end else begin
          word_d = qe_q;
          base_d = base_est;
        end
        state_d = S_RD;
      end
      S_RD: begin
        ram_en  = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (wr_q) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end
        if (!wr_q && ((ram_rdata & mask) != '0)) begin
          hit_d   = 1'b1;
          state_d = S_RESP;
        end else if (last_word) begin
          state_d = wr_q ? S_IDLE : S_RESP;
        end else begin
          word_d  = word_q + IDX_W'(1);
          base_d  = top;
          state_d = S_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          answer_d    = hit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qe_q     <= qe_d;
    base_q   <= base_d;
    start_q  <= start_d;
    end_q    <= end_d;
    wr_q     <= wr_d;
    val_q    <= val_d;
    hit_q    <= hit_d;
    answer_q <= answer_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule

`default_nettype wire

// ===== rtl/core/bsrq_checker.sv =====
// Port-level checker of the bit store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "bitset_with_range_any_query_macros.svh"

module bsrq_checker import bsrq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [REQ_W-1:0] req_type_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             answer_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       query_in, result_out, out_held;

  assign query_in   = in_valid_i && !in_stall_o &&
                      (req_type_i == REQ_GET || req_type_i == REQ_ANY);
  assign result_out = out_valid_o && !out_stall_i;
  assign out_held   = out_valid_o && out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (query_in && !result_out) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!query_in && result_out) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `BSRQ_ASSERT_NXT(a_out_hold, out_held, out_valid_o && $stable(answer_o), "Answer changed.")
  `BSRQ_ASSERT_NXT(a_busy_after_query, query_in, in_stall_o, "Idle after a query.")
  `BSRQ_ASSERT_IMP(a_no_stray_result, out_valid_o, cnt_q != 2'd0, "Answer with no query.")
  `BSRQ_ASSERT_IMP(a_two_in_flight, cnt_q == 2'd2, in_stall_o, "Third query taken.")

endmodule

bind bitset_with_range_any_query bsrq_checker u_checker (.*);

`default_nettype wire
